/* rtl/mbad_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Masked block average downscaler package
// Shared constants, payload types and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mbad_pkg;

	localparam int MaxBlocks    = 64;
	localparam int MaxBlockSize = 16;
	localparam int TileW        = $clog2(MaxBlocks);
	localparam int SumW         = 16;
	localparam int CntW         = 9;

	localparam logic [1:0] REG_BLOCK_SIZE    = 2'd0;
	localparam logic [1:0] REG_ROW_PIXELS    = 2'd1;
	localparam logic [1:0] REG_BLOCKS_ACROSS = 2'd2;
	localparam logic [1:0] REG_USE_MASK      = 2'd3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       masked;
		logic       last_row;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] avg_red;
		logic [7:0] avg_green;
		logic [7:0] avg_blue;
		logic [8:0] pixel_count;
		logic       block_row_end;
	} tile_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             acc_en;     // accumulate the accepted pixel
		logic             clr_en;     // clear one accumulator entry
		logic [TileW-1:0] clr_addr;
		logic             rd_en;      // read one entry for the drain
		logic [TileW-1:0] rd_addr;
		logic             div_start;  // start the dividers on read data
		logic             last_tile;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic res_valid;  // output register holds a result
	} dp_sts_t;

endpackage
`default_nettype wire

/* rtl/mbad_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring divider
// Divides a 16-bit sum by a 9-bit count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mbad_div
	import mbad_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [SumW-1:0] dividend,
	input  wire logic [CntW-1:0] divisor,
	output logic                 busy,
	output logic [SumW-1:0]      quotient
);
	localparam int StepW = $clog2(SumW + 1);

	logic [SumW-1:0]  quo_q;
	logic [CntW:0]    rem_q;
	logic [CntW-1:0]  dsr_q;
	logic [StepW-1:0] step_q;
	logic [CntW+1:0]  trial;

	assign trial = {rem_q, quo_q[SumW-1]} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= StepW'(SumW);
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (step_q != '0) begin
			if (!trial[CntW+1]) begin
				rem_q <= trial[CntW:0];
				quo_q <= {quo_q[SumW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[CntW-1:0], quo_q[SumW-1]};
				quo_q <= {quo_q[SumW-2:0], 1'b0};
			end
		end
	end

	assign busy     = (step_q != '0);
	assign quotient = quo_q;
endmodule
`default_nettype wire

/* rtl/mbad_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Masked block average datapath
// Accumulator memory, three dividers and the output register.
// ----------------------------------------------------------------------------
module mbad_datapath
	import mbad_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dp_cmd_t          cmd,
	input  wire pixel_in_t        pix,
	input  wire logic [TileW-1:0] acc_addr,
	input  wire logic             use_mask,
	input  wire logic [8:0]       size_sq,
	input  wire logic             out_take,
	output dp_sts_t               sts,
	output tile_out_t             result
);
	localparam int EntW = 3 * SumW + CntW;

	logic [EntW-1:0] mem [MaxBlocks];
	logic [EntW-1:0] rd_s1;
	logic [EntW-1:0] wr_data;
	logic [EntW-1:0] acc_rd_q;
	logic            acc_pend_q;
	logic [TileW-1:0] acc_addr_q;
	pixel_in_t       pix_q;
	logic            last_q;
	logic            valid_q;
	logic [CntW-1:0] cnt_q;
	logic            res_valid_q;
	logic            wait_q;
	logic            res_load;
	logic            busy_r, busy_g, busy_b;
	logic [SumW-1:0] q_r, q_g, q_b;
	logic            tile_ok;
	tile_out_t       res_q;

	// Accumulate is a read-modify-write through acc_rd_q; the controller spaces
	// pixels so a read never meets a pending write to the same entry.
	always_ff @(posedge clk) begin
		if (cmd.acc_en) begin
			acc_rd_q <= mem[acc_addr];
		end
		if (cmd.rd_en) begin
			rd_s1 <= mem[cmd.rd_addr];
		end
		if (cmd.clr_en) begin
			mem[cmd.clr_addr] <= '0;
		end else if (acc_pend_q) begin
			mem[acc_addr_q] <= wr_data;
		end
		if (cmd.acc_en) begin
			acc_addr_q <= acc_addr;
			pix_q      <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) acc_pend_q <= 1'b0;
		else         acc_pend_q <= cmd.acc_en;
	end

	assign wr_data = {acc_rd_q[EntW-1 -: SumW] + SumW'(pix_q.red),
		acc_rd_q[EntW-SumW-1 -: SumW] + SumW'(pix_q.green),
		acc_rd_q[EntW-2*SumW-1 -: SumW] + SumW'(pix_q.blue),
		acc_rd_q[CntW-1:0] + 1'b1};

	assign tile_ok = (rd_s1[CntW-1:0] != '0) &&
		(!use_mask || ({rd_s1[CntW-1:0], 1'b0} >= {1'b0, size_sq}));

	mbad_div u_div_r (.clk, .arst_n, .start(cmd.div_start),
		.dividend(rd_s1[EntW-1 -: SumW]), .divisor(rd_s1[CntW-1:0]),
		.busy(busy_r), .quotient(q_r));
	mbad_div u_div_g (.clk, .arst_n, .start(cmd.div_start),
		.dividend(rd_s1[EntW-SumW-1 -: SumW]), .divisor(rd_s1[CntW-1:0]),
		.busy(busy_g), .quotient(q_g));
	mbad_div u_div_b (.clk, .arst_n, .start(cmd.div_start),
		.dividend(rd_s1[EntW-2*SumW-1 -: SumW]), .divisor(rd_s1[CntW-1:0]),
		.busy(busy_b), .quotient(q_b));

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			valid_q <= tile_ok;
			cnt_q   <= use_mask ? rd_s1[CntW-1:0] : size_sq;
			last_q  <= cmd.last_tile;
		end
	end

	// The quotients move to the output register once the dividers finish and
	// the previous result has been taken.
	assign res_load = wait_q && !busy_r && !res_valid_q && !cmd.div_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.div_start) begin
				wait_q <= 1'b1;
			end else if (res_load) begin
				wait_q <= 1'b0;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (out_take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.avg_red       <= valid_q ? q_r[7:0] : 8'd0;
			res_q.avg_green     <= valid_q ? q_g[7:0] : 8'd0;
			res_q.avg_blue      <= valid_q ? q_b[7:0] : 8'd0;
			res_q.pixel_count   <= valid_q ? cnt_q : 9'd0;
			res_q.block_row_end <= last_q;
		end
	end

	assign sts.div_busy  = busy_r | busy_g | busy_b | wait_q;
	assign sts.res_valid = res_valid_q;
	assign result        = res_q;
endmodule
`default_nettype wire

/* rtl/mbad_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Masked block average controller
// Tracks position in the frame and sequences accumulate, drain and clear.
// ----------------------------------------------------------------------------
module mbad_ctrl
	import mbad_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_fire,
	input  wire pixel_in_t        pix,
	input  wire logic [4:0]       eff_size,
	input  wire logic [10:0]      eff_pixels,
	input  wire logic [6:0]       eff_across,
	input  wire logic             use_mask,
	input  wire dp_sts_t          sts,
	output logic                  in_ready,
	output logic [TileW-1:0]      acc_addr,
	output dp_cmd_t               cmd
);
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_WAIT  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_START = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_CLEAR = 6'b100000
	} state_t;

	state_t          state_q;
	logic [9:0]      col_q;
	logic [4:0]      row_q;
	logic [TileW:0]  k_q;
	logic            drain_q;  // the accepted pixel closed a block row
	logic [14:0]     recip;    // ceil(2^14 / tile edge)
	logic [23:0]     prod;
	logic [9:0]      tile_idx; // column divided by the tile edge
	logic            in_tile;
	logic            row_end;
	logic            emit;
	logic [4:0]      row_nx;

	// The tile index is the column times a rounded-up reciprocal of the tile
	// edge; with 14 fraction bits the quotient is exact for every column.
	always_comb begin
		unique case (eff_size)
			5'd1:    recip = 15'd16384;
			5'd2:    recip = 15'd8192;
			5'd3:    recip = 15'd5462;
			5'd4:    recip = 15'd4096;
			5'd5:    recip = 15'd3277;
			5'd6:    recip = 15'd2731;
			5'd7:    recip = 15'd2341;
			5'd8:    recip = 15'd2048;
			5'd9:    recip = 15'd1821;
			5'd10:   recip = 15'd1639;
			5'd11:   recip = 15'd1490;
			5'd12:   recip = 15'd1366;
			5'd13:   recip = 15'd1261;
			5'd14:   recip = 15'd1171;
			5'd15:   recip = 15'd1093;
			default: recip = 15'd1024;
		endcase
	end

	assign prod     = {14'd0, col_q} * {9'd0, recip};
	assign tile_idx = prod[23:14];

	assign in_tile = (tile_idx < {3'd0, eff_across});
	assign acc_addr = tile_idx[TileW-1:0];
	assign row_end = ({1'b0, col_q} + 11'd1 >= eff_pixels);
	assign row_nx  = row_q + 5'd1;
	assign emit    = row_end && ((row_nx >= eff_size) || pix.last_row);
	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			k_q     <= '0;
			drain_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (row_end) begin
							col_q <= '0;
							row_q <= emit ? 5'd0 : row_nx;
						end else begin
							col_q <= col_q + 10'd1;
						end
						k_q     <= '0;
						drain_q <= emit;
						state_q <= ST_WAIT;
					end
				end
				// The write-back of the accepted pixel lands here, so the
				// drain reads only after it.
				ST_WAIT:  state_q <= drain_q ? ST_READ : ST_IDLE;
				ST_READ:  state_q <= ST_START;
				ST_START: state_q <= ST_DIV;
				ST_DIV: begin
					if (!sts.div_busy) begin
						if (k_q + 1'b1 >= {1'b0, eff_across[TileW:0]} ||
							k_q[TileW-1:0] == '1) begin
							k_q     <= '0;
							state_q <= ST_CLEAR;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_CLEAR: begin
					if (k_q[TileW-1:0] == '1) begin
						k_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.acc_en    = in_fire && in_tile && !(use_mask && pix.masked);
		cmd.rd_en     = (state_q == ST_READ);
		cmd.rd_addr   = k_q[TileW-1:0];
		cmd.div_start = (state_q == ST_START);
		cmd.last_tile = (k_q + 1'b1 >= {1'b0, eff_across[TileW:0]}) ||
			(k_q[TileW-1:0] == '1);
		cmd.clr_en    = (state_q == ST_CLEAR);
		cmd.clr_addr  = k_q[TileW-1:0];
	end
endmodule
`default_nettype wire

/* rtl/masked_block_average_downscale.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Masked block average downscaler
// Averages RGB pixels over square tiles, optionally skipping masked pixels.
// ----------------------------------------------------------------------------
// Pixels enter on the in channel (in_valid/in_ready) in raster order, one
// transaction per pixel. Each pixel is a read-modify-write of its tile's
// accumulator entry in the accumulator memory, so in_ready drops after
// every accepted pixel.
// When the pixel that closes a block row is accepted, the controller drains
// one tile result per transaction on the out channel (out_valid/out_ready),
// left to right, with block_row_end set on the last tile. Each tile takes
// one memory read and a run of the bit-serial dividers.
// A stalled receiver holds the output register and stops the drain.
// After the drain a clearing sweep zeroes every accumulator entry; no pixel
// is accepted meanwhile. Reset returns the registers to their defaults and
// the counters to zero. The accumulator memory is not cleared by reset; a
// sweep over every entry runs after reset before the first pixel.
// Configuration writes via cfg_we/cfg_index/cfg_data take effect at once.
// ----------------------------------------------------------------------------
module masked_block_average_downscale
	import mbad_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire pixel_in_t  in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output tile_out_t       out_data,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [10:0] cfg_data
);
	logic [4:0]  block_size_q;
	logic [10:0] row_pixels_q;
	logic [6:0]  blocks_across_q;
	logic        use_mask_q;
	logic [4:0]  eff_size;
	logic [10:0] eff_pixels;
	logic [6:0]  eff_across;
	logic [8:0]  size_sq;
	logic        ctrl_ready;
	logic        in_fire;
	logic [TileW:0] init_q;   // reset clearing sweep counter
	logic        init_busy;
	dp_cmd_t     cmd, cmd_ctrl;
	dp_sts_t     sts;
	logic [TileW-1:0] acc_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q    <= 5'd8;
			row_pixels_q    <= 11'd640;
			blocks_across_q <= 7'd64;
			use_mask_q      <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLOCK_SIZE:    block_size_q    <= cfg_data[4:0];
				REG_ROW_PIXELS:    row_pixels_q    <= cfg_data;
				REG_BLOCKS_ACROSS: blocks_across_q <= cfg_data[6:0];
				REG_USE_MASK:      use_mask_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Out-of-range settings are clamped into their legal ranges.
	assign eff_size   = (block_size_q == '0) ? 5'd1 :
		(block_size_q > 5'(MaxBlockSize)) ? 5'(MaxBlockSize) : block_size_q;
	assign eff_pixels = (row_pixels_q == '0) ? 11'd1 :
		(row_pixels_q > 11'd1024) ? 11'd1024 : row_pixels_q;
	assign eff_across = (blocks_across_q == '0) ? 7'd1 :
		(blocks_across_q > 7'(MaxBlocks)) ? 7'(MaxBlocks) : blocks_across_q;
	assign size_sq = 9'(eff_size * eff_size);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
		end else if (init_busy) begin
			init_q <= init_q + 1'b1;
		end
	end
	assign init_busy = !init_q[TileW];

	assign in_ready = ctrl_ready && !init_busy;
	assign in_fire  = in_valid && in_ready;

	mbad_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .pix(in_data), .eff_size, .eff_pixels,
		.eff_across, .use_mask(use_mask_q), .sts, .in_ready(ctrl_ready),
		.acc_addr, .cmd(cmd_ctrl)
	);

	always_comb begin
		cmd = cmd_ctrl;
		if (init_busy) begin
			cmd.clr_en   = 1'b1;
			cmd.clr_addr = init_q[TileW-1:0];
		end
	end

	mbad_datapath u_dp (
		.clk, .arst_n, .cmd, .pix(in_data), .acc_addr, .use_mask(use_mask_q),
		.size_sq, .out_take(out_ready), .sts, .result(out_data)
	);

	assign out_valid = sts.res_valid;

`ifndef SYNTHESIS
	// No pixel is taken while the reset sweep is clearing the memory.
	a_no_pixel_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !in_ready) else $error("pixel accepted during sweep");
	// Accepting a pixel always leaves a gap before the next one.
	a_pixel_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready) else $error("back-to-back pixels");
	// A waiting result must not be dropped without a handshake.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result lost");
`endif
endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked block average downscaler testbench
// Streams pixel rows through the block in masked and plain modes over several
// tile geometries, predicts every tile mean and compares each drained result.
// ----------------------------------------------------------------------------
module testbench;
	import mbad_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	pixel_in_t in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	tile_out_t out_data;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_BLOCK_SIZE;
	logic [10:0] cfg_data = '0;

	masked_block_average_downscale uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Shadow copy of the block's registers and accumulator row.
	logic [4:0]  tile_edge = 5'd8;
	logic [10:0] pixels_per_row = 11'd640;
	logic [6:0]  tiles_per_row = 7'd64;
	logic        mask_mode = 1'b1;
	logic [15:0] red_acc [MaxBlocks];
	logic [15:0] green_acc [MaxBlocks];
	logic [15:0] blue_acc [MaxBlocks];
	logic [8:0]  count_acc [MaxBlocks];
	int unsigned column_now = 0;
	int unsigned rows_in_band = 0;

	tile_out_t pending_tiles [$];
	int        error_count = 0;
	int        pixels_sent = 0;
	int        tiles_seen = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        quiet_cycles = 0;

	function automatic int unsigned edge_eff();
		if (tile_edge == 0) return 1;
		if (tile_edge > MaxBlockSize) return MaxBlockSize;
		return tile_edge;
	endfunction

	function automatic int unsigned across_eff();
		if (tiles_per_row == 0) return 1;
		if (tiles_per_row > MaxBlocks) return MaxBlocks;
		return tiles_per_row;
	endfunction

	function automatic int unsigned width_eff();
		if (pixels_per_row == 0) return 1;
		if (pixels_per_row > 1024) return 1024;
		return pixels_per_row;
	endfunction

	function automatic void clear_band();
		for (int k = 0; k < MaxBlocks; k++) begin
			red_acc[k] = '0;
			green_acc[k] = '0;
			blue_acc[k] = '0;
			count_acc[k] = '0;
		end
	endfunction

	// Accumulates one pixel and, when it closes a block row, queues the expected
	// result of every tile of that row, zero for a rejected tile.
	function automatic void accumulate_pixel(pixel_in_t px);
		int unsigned n;
		int unsigned across;
		int unsigned tile;
		int unsigned c;
		bit ok;
		tile_out_t t;
		n = edge_eff();
		across = across_eff();
		tile = column_now / n;
		if (tile < across && !(mask_mode && px.masked)) begin
			red_acc[tile] += px.red;
			green_acc[tile] += px.green;
			blue_acc[tile] += px.blue;
			count_acc[tile] += 1;
		end
		if (column_now + 1 < width_eff()) begin
			column_now++;
			return;
		end
		column_now = 0;
		rows_in_band++;
		if (rows_in_band < n && !px.last_row) return;
		for (int k = 0; k < across; k++) begin
			c = count_acc[k];
			ok = mask_mode ? (c != 0 && 2 * c >= n * n) : (c != 0);
			t = '0;
			if (ok) begin
				t.avg_red = 8'(red_acc[k] / c);
				t.avg_green = 8'(green_acc[k] / c);
				t.avg_blue = 8'(blue_acc[k] / c);
				t.pixel_count = 9'(mask_mode ? c : n * n);
			end
			t.block_row_end = (k + 1 == across);
			pending_tiles.push_back(t);
		end
		clear_band();
		rows_in_band = 0;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on tile %0d: %s got %0d expected %0d", tiles_seen, what, got, want);
		error_count++;
	endtask

	// Receiver side: stalls at random and checks each tile transaction.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		tile_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_tiles.size() == 0) begin
				report_mismatch("unexpected tile", 1, 0);
			end else begin
				want = pending_tiles.pop_front();
				if (out_data.avg_red !== want.avg_red)
					report_mismatch("avg_red", out_data.avg_red, want.avg_red);
				if (out_data.avg_green !== want.avg_green)
					report_mismatch("avg_green", out_data.avg_green, want.avg_green);
				if (out_data.avg_blue !== want.avg_blue)
					report_mismatch("avg_blue", out_data.avg_blue, want.avg_blue);
				if (out_data.pixel_count !== want.pixel_count)
					report_mismatch("pixel_count", out_data.pixel_count, want.pixel_count);
				if (out_data.block_row_end !== want.block_row_end)
					report_mismatch("block_row_end", out_data.block_row_end,
						want.block_row_end);
			end
			tiles_seen++;
		end
	end

	// Watchdog: the drain and the clearing sweep each end well inside the quiet
	// limit, even with the receiver stalling most of the time.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 40000) begin
			$display("watchdog expired");
			$display("masked_block_average_downscale regression: fail");
			$finish;
		end
	end

	// Sends one pixel transaction, with a random gap first. Valid drops only
	// in a gap or when the sender waits, so back-to-back pixels stay high.
	task automatic send_pixel(input pixel_in_t px);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= px;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		accumulate_pixel(px);
		pixels_sent++;
		@(negedge clk);
	endtask

	function automatic pixel_in_t random_pixel(input int mask_pct, input bit last);
		pixel_in_t px;
		px.red = $urandom;
		px.green = $urandom;
		px.blue = $urandom;
		px.masked = ($urandom_range(99) < mask_pct);
		px.last_row = last;
		return px;
	endfunction

	// Waits until the drain is over plus the clearing sweep.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_tiles.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [10:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		case (idx)
			REG_BLOCK_SIZE:    tile_edge = value[4:0];
			REG_ROW_PIXELS:    pixels_per_row = value;
			REG_BLOCKS_ACROSS: tiles_per_row = value[6:0];
			default:           mask_mode = value[0];
		endcase
	endtask

	task automatic set_geometry(input int n, input int w, input int across, input bit msk);
		wait_idle();
		write_reg(REG_BLOCK_SIZE, 11'(n));
		write_reg(REG_ROW_PIXELS, 11'(w));
		write_reg(REG_BLOCKS_ACROSS, 11'(across));
		write_reg(REG_USE_MASK, 11'(msk));
		cfg_we <= 1'b0;
	endtask

	// Sends whole rows; the last row of the frame carries last_row.
	task automatic send_rows(input int rows, input int mask_pct, input bit end_frame);
		int w;
		w = width_eff();
		for (int r = 0; r < rows; r++)
			for (int c = 0; c < w; c++)
				send_pixel(random_pixel(mask_pct, end_frame && r == rows - 1));
	endtask

	// Extremes: white and black tiles, and a tile right at the half-full
	// threshold in masked mode.
	task automatic test_directed_extremes();
		pixel_in_t px;
		set_geometry(2, 4, 2, 1'b1);
		for (int i = 0; i < 8; i++) begin
			px = '0;
			if (i % 4 < 2) begin
				px.red = 8'hFF; px.green = 8'hFF; px.blue = 8'hFF;
			end else begin
				px.masked = (i >= 6);
			end
			send_pixel(px);
		end
		// Plain mode: masked flags are ignored; stray pixels past the tiles.
		set_geometry(2, 5, 2, 1'b0);
		for (int i = 0; i < 5; i++) begin
			px = '0;
			px.red = 8'hAA; px.green = 8'h55; px.blue = 8'h0F;
			px.masked = 1'b1;
			px.last_row = (i == 4);
			send_pixel(px);
		end
		// Out-of-range register values act as clamped limits.
		set_geometry(0, 0, 0, 1'b1);
		px = '0; px.red = 8'h80; px.green = 8'h01; px.blue = 8'hFE;
		send_pixel(px);
		px.masked = 1'b1;
		send_pixel(px);
	endtask

	// Random frames over a set of geometries, including the largest tiles.
	task automatic test_random_frames(input int budget);
		int n, across, w, rows;
		while (budget > 0) begin
			n = ($urandom_range(9) == 0) ? 16 : $urandom_range(1, 3);
			across = $urandom_range(1, 4);
			w = n * across + $urandom_range(0, 2) - (n > 1 ? $urandom_range(0, 1) : 0);
			if (n == 16) begin
				w = 16; across = $urandom_range(1, 2);
			end
			set_geometry(n, w, across, $urandom_range(1));
			rows = (n == 16) ? 1 : $urandom_range(1, n);
			send_rows(rows, $urandom_range(0, 60), 1'b1);
			budget -= w * rows;
		end
	endtask

	// Mid-row geometry with a pause that lets every drain finish first.
	task automatic test_pause_drain();
		set_geometry(4, 8, 2, 1'b1);
		send_rows(4, 20, 1'b0);
		in_valid <= 1'b0;
		while (pending_tiles.size() != 0) @(negedge clk);
		send_rows(2, 70, 1'b1);
	endtask

	initial begin
		clear_band();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		repeat (80) @(negedge clk);
		test_directed_extremes();
		send_idle_pct = 0; recv_stall_pct = 0;
		test_random_frames(70);
		send_idle_pct = 59; recv_stall_pct = 0;
		test_random_frames(70);
		send_idle_pct = 0; recv_stall_pct = 59;
		test_random_frames(70);
		send_idle_pct = 31; recv_stall_pct = 31;
		test_pause_drain();
		test_random_frames(70);
		send_idle_pct = 0; recv_stall_pct = 0;
		set_geometry(8, 640, 64, 1'b1);
		wait_idle();
		$display("Sent %0d pixels over masked and plain modes and several tile sizes;",
			pixels_sent);
		$display("checked %0d tile results.", tiles_seen);
		if (error_count == 0)
			$display("masked_block_average_downscale regression: pass");
		else
			$display("masked_block_average_downscale regression: fail");
		$finish;
	end

endmodule

/* sim.f */
rtl/mbad_pkg.sv
rtl/mbad_div.sv
rtl/mbad_datapath.sv
rtl/mbad_ctrl.sv
rtl/masked_block_average_downscale.sv
dv/testbench.sv
